### rtl/sdh_pkg.sv
// Shared types and constants for the supply detector with hysteresis.
package sdh_pkg;

  // Sample count per check; extra samples past the third reuse sample_c
  localparam int NUM_SAMPLES = 3;

  // Field widths
  localparam int RAW_W     = 12;
  localparam int CAL_W     = 12;
  localparam int TH_W      = 16;
  localparam int REF_W     = 16;
  localparam int DIVIDEND_W = 24;
  localparam int REM_W     = 12;
  localparam int PROD_W    = RAW_W + REF_W;
  localparam int SCALE_SH  = 12;
  localparam int MVX_W     = PROD_W - SCALE_SH;
  localparam int MV_W      = MVX_W + 2;

  // Divider sequencing
  localparam int DIV_STEPS = DIVIDEND_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Scaling sequencing: one multiply per sample plus the confirm sample,
  // evaluation following in the cycle after each multiply
  localparam int SCALE_LAST = NUM_SAMPLES + 1;
  localparam int SCNT_W     = $clog2(SCALE_LAST + 1);

  // Reference multiplier in millivolts
  localparam logic [DIVIDEND_W-1:0] REF_MV = DIVIDEND_W'(3300);

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_UP_TH   = 2'd0;
  localparam logic [1:0] REG_DOWN_TH = 2'd1;
  localparam logic [1:0] REG_VREF_CAL = 2'd2;

  localparam logic [TH_W-1:0]  UP_TH_RST   = TH_W'(4900);
  localparam logic [TH_W-1:0]  DOWN_TH_RST = TH_W'(4700);
  localparam logic [CAL_W-1:0] VREF_CAL_RST = CAL_W'(1526);

  // Power status codes
  typedef enum logic [2:0] {
    ST_BATTERY = 3'd0,
    ST_AC      = 3'd1,
    ST_DC      = 3'd2,
    ST_AUX     = 3'd3,
    ST_WAKEUP  = 3'd4,
    ST_REBOOT  = 3'd5,
    ST_RESET   = 3'd6,
    ST_UNUSED  = 3'd7
  } status_t;

  // Multiplier operand select
  typedef enum logic [1:0] {
    SEL_A    = 2'd0,
    SEL_B    = 2'd1,
    SEL_C    = 2'd2,
    SEL_CONF = 2'd3
  } sel_t;

  typedef struct packed {
    logic [TH_W-1:0]  up_th;
    logic [TH_W-1:0]  down_th;
    logic [CAL_W-1:0] vref_cal;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    sel_t sel;
    logic eval;
    logic eval_confirm;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_check;
    logic vref_zero;
  } stat_t;

endpackage

### rtl/supply_detect_with_hysteresis_top.sv
// Top level of the supply detector with hysteresis.
// One item is processed at a time. A poll, or an alter-to-battery request,
// with a nonzero reference reading passes through capture, route, 24 steps
// of the one-bit-per-cycle reference divider, scaling on the shared
// multiplier and commit; every other item goes from capture through route
// straight to commit. A new item is accepted while a finished result
// still waits on out_stall; the next result is committed only once the
// waiting one has been taken.
// Configuration registers sit at byte addresses 0 (up threshold), 4 (down
// threshold) and 8 (reference calibration); the user must see that they are
// written only while idle, as the block itself does not enforce this.
module supply_detect_with_hysteresis_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [2:0]                 in_requested_status,
  input  logic [sdh_pkg::RAW_W-1:0]  in_vrefint_raw,
  input  logic [sdh_pkg::RAW_W-1:0]  in_sample_a,
  input  logic [sdh_pkg::RAW_W-1:0]  in_sample_b,
  input  logic [sdh_pkg::RAW_W-1:0]  in_sample_c,
  input  logic [sdh_pkg::RAW_W-1:0]  in_confirm_sample,
  // Result items
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_status,
  // Configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sdh_pkg::ADDR_W-1:0] paddr,
  input  logic [sdh_pkg::DATA_W-1:0] pwdata,
  output logic [sdh_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  sdh_pkg::cfg_t  cfg;
  sdh_pkg::cmd_t  cmd;
  sdh_pkg::stat_t stat;

  sdh_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sdh_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .stat                (stat),
    .in_op               (in_op),
    .in_requested_status (in_requested_status),
    .in_vrefint_raw      (in_vrefint_raw),
    .in_sample_a         (in_sample_a),
    .in_sample_b         (in_sample_b),
    .in_sample_c         (in_sample_c),
    .in_confirm_sample   (in_confirm_sample),
    .out_status          (out_status)
  );

endmodule

### rtl/sdh_regs.sv
// Configuration register file behind the APB-style port.
module sdh_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sdh_pkg::ADDR_W-1:0]  paddr,
  input  logic [sdh_pkg::DATA_W-1:0]  pwdata,
  output logic [sdh_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output sdh_pkg::cfg_t               cfg
);

  logic [sdh_pkg::TH_W-1:0]  up_th_r;
  logic [sdh_pkg::TH_W-1:0]  down_th_r;
  logic [sdh_pkg::CAL_W-1:0] vref_cal_r;
  logic [1:0]                reg_idx;
  logic                      wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_th_r    <= sdh_pkg::UP_TH_RST;
      down_th_r  <= sdh_pkg::DOWN_TH_RST;
      vref_cal_r <= sdh_pkg::VREF_CAL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        sdh_pkg::REG_UP_TH:    up_th_r    <= pwdata[sdh_pkg::TH_W-1:0];
        sdh_pkg::REG_DOWN_TH:  down_th_r  <= pwdata[sdh_pkg::TH_W-1:0];
        sdh_pkg::REG_VREF_CAL: vref_cal_r <= pwdata[sdh_pkg::CAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      sdh_pkg::REG_UP_TH:    prdata = sdh_pkg::DATA_W'(up_th_r);
      sdh_pkg::REG_DOWN_TH:  prdata = sdh_pkg::DATA_W'(down_th_r);
      sdh_pkg::REG_VREF_CAL: prdata = sdh_pkg::DATA_W'(vref_cal_r);
      default:               prdata = '0;
    endcase
  end

  assign cfg.up_th    = up_th_r;
  assign cfg.down_th  = down_th_r;
  assign cfg.vref_cal = vref_cal_r;

endmodule

### rtl/sdh_dp.sv
// Datapath: item capture, reference divider, sample scaling and status update.
module sdh_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sdh_pkg::cfg_t              cfg,
  input  sdh_pkg::cmd_t              cmd,
  output sdh_pkg::stat_t             stat,
  input  logic                       in_op,
  input  logic [2:0]                 in_requested_status,
  input  logic [sdh_pkg::RAW_W-1:0]  in_vrefint_raw,
  input  logic [sdh_pkg::RAW_W-1:0]  in_sample_a,
  input  logic [sdh_pkg::RAW_W-1:0]  in_sample_b,
  input  logic [sdh_pkg::RAW_W-1:0]  in_sample_c,
  input  logic [sdh_pkg::RAW_W-1:0]  in_confirm_sample,
  output logic [2:0]                 out_status
);

  // Captured item
  logic                         op_r;
  sdh_pkg::status_t             req_r;
  logic [sdh_pkg::RAW_W-1:0]    vref_r;
  logic [sdh_pkg::RAW_W-1:0]    samp_a_r;
  logic [sdh_pkg::RAW_W-1:0]    samp_b_r;
  logic [sdh_pkg::RAW_W-1:0]    samp_c_r;
  logic [sdh_pkg::RAW_W-1:0]    samp_conf_r;

  // Divider: quotient shifts in where the dividend shifts out
  logic [sdh_pkg::DIVIDEND_W-1:0] quo_r;
  logic [sdh_pkg::REM_W-1:0]      rem_r;
  logic [sdh_pkg::REM_W:0]        rem_sh;
  logic                           rem_ge;

  // Scaling
  logic [sdh_pkg::RAW_W-1:0]  mul_raw;
  logic [sdh_pkg::PROD_W-1:0] prod_r;
  logic [sdh_pkg::MVX_W-1:0]  mv_x;
  logic [sdh_pkg::MV_W-1:0]   mv;
  logic                       mv_up;
  logic                       mv_down;
  logic                       all_up_r;
  logic                       all_down_r;
  logic                       conf_up_r;
  logic                       conf_down_r;

  // Architectural state
  logic                       det_r;
  sdh_pkg::status_t           cur_r;
  logic                       chk;
  sdh_pkg::status_t           cur_nxt;

  // Capture the item and the dividend
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_op;
      req_r       <= sdh_pkg::status_t'(in_requested_status);
      vref_r      <= in_vrefint_raw;
      samp_a_r    <= in_sample_a;
      samp_b_r    <= in_sample_b;
      samp_c_r    <= in_sample_c;
      samp_conf_r <= in_confirm_sample;
    end
  end

  // One quotient bit per step
  assign rem_sh = {rem_r, quo_r[sdh_pkg::DIVIDEND_W-1]};
  assign rem_ge = rem_sh >= {1'b0, vref_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r <= sdh_pkg::DIVIDEND_W'(cfg.vref_cal) * sdh_pkg::REF_MV;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem_r <= sdh_pkg::REM_W'(rem_sh - {1'b0, vref_r});
      end else begin
        rem_r <= rem_sh[sdh_pkg::REM_W-1:0];
      end
      quo_r <= {quo_r[sdh_pkg::DIVIDEND_W-2:0], rem_ge};
    end
  end

  // Select the reading for the shared multiplier
  always_comb begin
    unique case (cmd.sel)
      sdh_pkg::SEL_A:    mul_raw = samp_a_r;
      sdh_pkg::SEL_B:    mul_raw = samp_b_r;
      sdh_pkg::SEL_C:    mul_raw = samp_c_r;
      sdh_pkg::SEL_CONF: mul_raw = samp_conf_r;
      default:           mul_raw = samp_a_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= sdh_pkg::PROD_W'(mul_raw) * sdh_pkg::PROD_W'(quo_r[sdh_pkg::REF_W-1:0]);
    end
  end

  // Millivolts: drop the ADC fraction, then times three
  assign mv_x    = prod_r[sdh_pkg::PROD_W-1:sdh_pkg::SCALE_SH];
  assign mv      = {1'b0, mv_x, 1'b0} + sdh_pkg::MV_W'(mv_x);
  assign mv_up   = mv > sdh_pkg::MV_W'(cfg.up_th);
  assign mv_down = mv < sdh_pkg::MV_W'(cfg.down_th);

  // Accumulate the threshold votes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      all_up_r   <= 1'b1;
      all_down_r <= 1'b1;
    end else if (cmd.eval) begin
      if (cmd.eval_confirm) begin
        conf_up_r   <= mv_up;
        conf_down_r <= mv_down;
      end else begin
        all_up_r   <= all_up_r & mv_up;
        all_down_r <= all_down_r & mv_down;
      end
    end
  end

  assign stat.need_check = !op_r || (req_r == sdh_pkg::ST_BATTERY);
  assign stat.vref_zero  = (vref_r == '0);

  // Check result with hysteresis
  always_comb begin
    if (stat.vref_zero) begin
      chk = 1'b0;
    end else if (!det_r) begin
      chk = all_up_r & conf_up_r;
    end else begin
      chk = !(all_down_r & conf_down_r);
    end
  end

  // Next status under the latching rules
  always_comb begin
    cur_nxt = cur_r;
    if (!op_r) begin
      if (!((cur_r == sdh_pkg::ST_WAKEUP && !chk) || cur_r == sdh_pkg::ST_REBOOT ||
            cur_r == sdh_pkg::ST_RESET)) begin
        cur_nxt = chk ? sdh_pkg::ST_AC : sdh_pkg::ST_BATTERY;
      end
    end else begin
      unique case (req_r)
        sdh_pkg::ST_WAKEUP: begin
          if (cur_r == sdh_pkg::ST_BATTERY) cur_nxt = sdh_pkg::ST_WAKEUP;
        end
        sdh_pkg::ST_BATTERY: begin
          cur_nxt = chk ? sdh_pkg::ST_AC : sdh_pkg::ST_BATTERY;
        end
        sdh_pkg::ST_REBOOT: begin
          cur_nxt = sdh_pkg::ST_REBOOT;
        end
        sdh_pkg::ST_RESET: begin
          if (cur_r == sdh_pkg::ST_AC || cur_r == sdh_pkg::ST_DC ||
              cur_r == sdh_pkg::ST_AUX) begin
            cur_nxt = sdh_pkg::ST_RESET;
          end
        end
        default: ;
      endcase
    end
  end

  // Commit the item's effect
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_r <= 1'b0;
      cur_r <= sdh_pkg::ST_BATTERY;
    end else if (cmd.commit) begin
      if (stat.need_check) det_r <= chk;
      cur_r <= cur_nxt;
    end
  end

  assign out_status = cur_r;

endmodule

### rtl/sdh_ctrl.sv
// Controller: sequences capture, division, scaling and result hand-off.
module sdh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  sdh_pkg::stat_t stat,
  output sdh_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUTE,
    S_DIV,
    S_SCALE,
    S_DONE
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  logic [sdh_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [sdh_pkg::DIV_CNT_W-1:0] div_cnt_nxt;
  logic [sdh_pkg::SCNT_W-1:0]  scnt_r;
  logic [sdh_pkg::SCNT_W-1:0]  scnt_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    scnt_nxt      = scnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.sel       = sdh_pkg::SEL_A;

    // Drop a result once taken
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ROUTE;
        end
      end
      S_ROUTE: begin
        div_cnt_nxt = '0;
        scnt_nxt    = '0;
        state_nxt   = (stat.need_check && !stat.vref_zero) ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == sdh_pkg::DIV_CNT_W'(sdh_pkg::DIV_STEPS - 1)) state_nxt = S_SCALE;
      end
      S_SCALE: begin
        // Multiply sample k while evaluating sample k-1
        cmd.mul = (scnt_r <= sdh_pkg::SCNT_W'(sdh_pkg::NUM_SAMPLES));
        if (scnt_r == sdh_pkg::SCNT_W'(sdh_pkg::NUM_SAMPLES)) begin
          cmd.sel = sdh_pkg::SEL_CONF;
        end else if (scnt_r >= sdh_pkg::SCNT_W'(2)) begin
          cmd.sel = sdh_pkg::SEL_C;
        end else if (scnt_r == sdh_pkg::SCNT_W'(1)) begin
          cmd.sel = sdh_pkg::SEL_B;
        end else begin
          cmd.sel = sdh_pkg::SEL_A;
        end
        cmd.eval         = (scnt_r != '0);
        cmd.eval_confirm = (scnt_r == sdh_pkg::SCNT_W'(sdh_pkg::SCALE_LAST));
        scnt_nxt         = scnt_r + 1'b1;
        if (scnt_r == sdh_pkg::SCNT_W'(sdh_pkg::SCALE_LAST)) state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hand over once the output register is free
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, counters and the output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      scnt_r      <= scnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("status committed over an untaken result");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_load_route: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_ROUTE))
    else $error("captured item not routed");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r <= sdh_pkg::DIV_CNT_W'(sdh_pkg::DIV_STEPS - 1)))
    else $error("divider ran past its last step");
`endif

endmodule

### dv/tb_supply_detect_with_hysteresis_top.sv
// Testbench for the supply detector: predicts the power status of every item and checks it.
`timescale 1ns / 1ps

module tb_supply_detect_with_hysteresis_top;

  localparam logic OP_POLL  = 1'b0;
  localparam logic OP_ALTER = 1'b1;

  // Raw readings that sit well clear of the reset thresholds at the nominal reference
  localparam logic [sdh_pkg::RAW_W-1:0] NOM_VREF = sdh_pkg::RAW_W'(1526);
  localparam logic [sdh_pkg::RAW_W-1:0] HI_RAW   = sdh_pkg::RAW_W'(3000);
  localparam logic [sdh_pkg::RAW_W-1:0] LO_RAW   = sdh_pkg::RAW_W'(1000);
  localparam logic [sdh_pkg::RAW_W-1:0] MAX_RAW  = '1;

  localparam int NUM_PHASES = 6;
  localparam int RANDOM_PER_PHASE = 66;

  typedef struct {
    logic                      op;
    logic [2:0]                req;
    logic [sdh_pkg::RAW_W-1:0] vref;
    logic [sdh_pkg::RAW_W-1:0] smp [4]; // sample_a, sample_b, sample_c, confirm
  } supply_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_op = 1'b0;
  logic [2:0]                in_requested_status = '0;
  logic [sdh_pkg::RAW_W-1:0] in_vrefint_raw = '0;
  logic [sdh_pkg::RAW_W-1:0] in_sample_a = '0;
  logic [sdh_pkg::RAW_W-1:0] in_sample_b = '0;
  logic [sdh_pkg::RAW_W-1:0] in_sample_c = '0;
  logic [sdh_pkg::RAW_W-1:0] in_confirm_sample = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [2:0]                out_status;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [sdh_pkg::ADDR_W-1:0] paddr = '0;
  logic [sdh_pkg::DATA_W-1:0] pwdata = '0;
  logic [sdh_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  // Predictor state and its copy of the registers
  logic [sdh_pkg::TH_W-1:0]  up_th_mv;
  logic [sdh_pkg::TH_W-1:0]  down_th_mv;
  logic [sdh_pkg::CAL_W-1:0] cal_reading;
  logic                      mains_seen;
  sdh_pkg::status_t          pred_status;

  supply_item_t     pending_items [$];
  sdh_pkg::status_t status_due [$];
  supply_item_t     cur_item;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      mismatches = 0;

  supply_detect_with_hysteresis_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_requested_status (in_requested_status),
    .in_vrefint_raw      (in_vrefint_raw),
    .in_sample_a         (in_sample_a),
    .in_sample_b         (in_sample_b),
    .in_sample_c         (in_sample_c),
    .in_confirm_sample   (in_confirm_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Reference in millivolts derived from the calibration, kept to 16 bits
  function automatic logic [sdh_pkg::REF_W-1:0] ref_from_vref(
      logic [sdh_pkg::CAL_W-1:0] cal, logic [sdh_pkg::RAW_W-1:0] vref);
    logic [31:0] q;
    q = (32'(cal) * 32'd3300) / 32'(vref);
    return q[sdh_pkg::REF_W-1:0];
  endfunction

  function automatic logic [31:0] scaled_mv(logic [sdh_pkg::RAW_W-1:0] raw,
                                            logic [sdh_pkg::REF_W-1:0] rf);
    logic [31:0] prod;
    prod = 32'(raw) * 32'(rf);
    return (prod >> 12) * 32'd3;
  endfunction

  // Supply check with hysteresis; updates the detected supply
  function automatic logic check_mains(supply_item_t it);
    logic [sdh_pkg::REF_W-1:0] rf;
    logic [31:0]               mv;
    logic                      all_up;
    logic                      all_down;
    if (it.vref == '0) begin
      mains_seen = 1'b0;
      return 1'b0;
    end
    rf = ref_from_vref(cal_reading, it.vref);
    all_up = 1'b1;
    all_down = 1'b1;
    for (int i = 0; i < sdh_pkg::NUM_SAMPLES; i++) begin
      mv = scaled_mv(it.smp[(i < 3) ? i : 2], rf);
      if (!(mv > 32'(up_th_mv))) all_up = 1'b0;
      if (!(mv < 32'(down_th_mv))) all_down = 1'b0;
    end
    mv = scaled_mv(it.smp[3], rf);
    if (!mains_seen) begin
      if (all_up && mv > 32'(up_th_mv)) mains_seen = 1'b1;
    end else begin
      if (all_down && mv < 32'(down_th_mv)) mains_seen = 1'b0;
    end
    return mains_seen;
  endfunction

  // Advance the status machine by one item and return the new status
  function automatic sdh_pkg::status_t next_pred_status(supply_item_t it);
    logic mains;
    if (it.op == OP_POLL) begin
      mains = check_mains(it);
      if (!((pred_status == sdh_pkg::ST_WAKEUP && !mains) ||
            pred_status == sdh_pkg::ST_REBOOT || pred_status == sdh_pkg::ST_RESET))
        pred_status = mains ? sdh_pkg::ST_AC : sdh_pkg::ST_BATTERY;
    end else begin
      case (sdh_pkg::status_t'(it.req))
        sdh_pkg::ST_WAKEUP: begin
          if (pred_status == sdh_pkg::ST_BATTERY) pred_status = sdh_pkg::ST_WAKEUP;
        end
        sdh_pkg::ST_BATTERY: begin
          pred_status = check_mains(it) ? sdh_pkg::ST_AC : sdh_pkg::ST_BATTERY;
        end
        sdh_pkg::ST_REBOOT: begin
          pred_status = sdh_pkg::ST_REBOOT;
        end
        sdh_pkg::ST_RESET: begin
          if (pred_status inside {sdh_pkg::ST_AC, sdh_pkg::ST_DC, sdh_pkg::ST_AUX})
            pred_status = sdh_pkg::ST_RESET;
        end
        default: ;
      endcase
    end
    return pred_status;
  endfunction

  function automatic supply_item_t make_item(logic op, logic [2:0] req,
                                             logic [sdh_pkg::RAW_W-1:0] vref,
                                             logic [sdh_pkg::RAW_W-1:0] a,
                                             logic [sdh_pkg::RAW_W-1:0] b,
                                             logic [sdh_pkg::RAW_W-1:0] c,
                                             logic [sdh_pkg::RAW_W-1:0] conf);
    supply_item_t it;
    it.op = op;
    it.req = req;
    it.vref = vref;
    it.smp[0] = a;
    it.smp[1] = b;
    it.smp[2] = c;
    it.smp[3] = conf;
    return it;
  endfunction

  // Raw reading that scales to roughly the given millivolts
  function automatic logic [sdh_pkg::RAW_W-1:0] raw_for_mv(int mv,
                                                           logic [sdh_pkg::REF_W-1:0] rf);
    longint r;
    if (rf == '0) return sdh_pkg::RAW_W'($urandom);
    r = (longint'(mv) * 4096) / (3 * longint'(rf));
    return (r > 4095) ? MAX_RAW : sdh_pkg::RAW_W'(r);
  endfunction

  // Mostly coherent readings around one threshold, with some noise mixed in
  function automatic supply_item_t random_item();
    supply_item_t              it;
    logic [sdh_pkg::REF_W-1:0] rf;
    int                        vr;
    int                        band;
    int                        mv;
    it.op = ($urandom_range(99) < 55) ? OP_POLL : OP_ALTER;
    it.req = 3'($urandom_range(7));
    if ($urandom_range(99) < 4) begin
      it.vref = '0;
    end else if ($urandom_range(99) < 12) begin
      it.vref = sdh_pkg::RAW_W'($urandom_range(4095, 1));
    end else begin
      vr = int'(cal_reading) + $urandom_range(128) - 64;
      it.vref = sdh_pkg::RAW_W'((vr < 1) ? 1 : (vr > 4095) ? 4095 : vr);
    end
    rf = (it.vref == '0) ? '0 : ref_from_vref(cal_reading, it.vref);
    band = $urandom_range(4);
    for (int i = 0; i < 4; i++) begin
      if (band == 4 || $urandom_range(9) == 0) begin
        it.smp[i] = sdh_pkg::RAW_W'($urandom);
      end else begin
        if (band < 2) mv = int'(up_th_mv) + $urandom_range(450) - 50;
        else mv = int'(down_th_mv) - $urandom_range(450) + 50;
        it.smp[i] = raw_for_mv((mv < 0) ? 0 : mv, rf);
      end
    end
    return it;
  endfunction

  task automatic load_directed_items();
    // Zero reference, wakeup hold on battery, confirm disagreeing
    pending_items.push_back(make_item(OP_POLL, sdh_pkg::ST_BATTERY, '0,
                                      MAX_RAW, MAX_RAW, MAX_RAW, MAX_RAW));
    pending_items.push_back(make_item(OP_ALTER, sdh_pkg::ST_WAKEUP, NOM_VREF,
                                      LO_RAW, LO_RAW, LO_RAW, LO_RAW));
    pending_items.push_back(make_item(OP_POLL, sdh_pkg::ST_BATTERY, NOM_VREF,
                                      LO_RAW, LO_RAW, LO_RAW, LO_RAW));
    pending_items.push_back(make_item(OP_POLL, sdh_pkg::ST_BATTERY, NOM_VREF,
                                      HI_RAW, HI_RAW, HI_RAW, LO_RAW));
    pending_items.push_back(make_item(OP_POLL, sdh_pkg::ST_BATTERY, NOM_VREF,
                                      HI_RAW, HI_RAW, HI_RAW, HI_RAW));
    // Reset latch, the requests it refuses, and an alter to battery that leaves it
    pending_items.push_back(make_item(OP_ALTER, sdh_pkg::ST_RESET, NOM_VREF,
                                      LO_RAW, LO_RAW, LO_RAW, LO_RAW));
    pending_items.push_back(make_item(OP_POLL, sdh_pkg::ST_BATTERY, NOM_VREF,
                                      LO_RAW, LO_RAW, LO_RAW, LO_RAW));
    pending_items.push_back(make_item(OP_ALTER, sdh_pkg::ST_WAKEUP, NOM_VREF,
                                      HI_RAW, HI_RAW, HI_RAW, HI_RAW));
    pending_items.push_back(make_item(OP_ALTER, sdh_pkg::ST_BATTERY, NOM_VREF,
                                      HI_RAW, HI_RAW, HI_RAW, HI_RAW));
    // Requests that change nothing, the last with every field at its top
    pending_items.push_back(make_item(OP_ALTER, sdh_pkg::ST_AC, NOM_VREF,
                                      LO_RAW, LO_RAW, LO_RAW, LO_RAW));
    pending_items.push_back(make_item(OP_ALTER, sdh_pkg::ST_DC, NOM_VREF,
                                      LO_RAW, LO_RAW, LO_RAW, LO_RAW));
    pending_items.push_back(make_item(OP_ALTER, sdh_pkg::ST_AUX, NOM_VREF,
                                      LO_RAW, LO_RAW, LO_RAW, LO_RAW));
    pending_items.push_back(make_item(OP_ALTER, sdh_pkg::ST_UNUSED, MAX_RAW,
                                      MAX_RAW, MAX_RAW, MAX_RAW, MAX_RAW));
    // Reboot latch, then alter to battery with and without a switch
    pending_items.push_back(make_item(OP_ALTER, sdh_pkg::ST_REBOOT, NOM_VREF,
                                      LO_RAW, LO_RAW, LO_RAW, LO_RAW));
    pending_items.push_back(make_item(OP_POLL, sdh_pkg::ST_BATTERY, NOM_VREF,
                                      HI_RAW, HI_RAW, HI_RAW, HI_RAW));
    pending_items.push_back(make_item(OP_ALTER, sdh_pkg::ST_BATTERY, NOM_VREF,
                                      LO_RAW, LO_RAW, LO_RAW, HI_RAW));
    pending_items.push_back(make_item(OP_ALTER, sdh_pkg::ST_BATTERY, '0,
                                      HI_RAW, HI_RAW, HI_RAW, HI_RAW));
    // Readings right at the up threshold
    pending_items.push_back(make_item(OP_POLL, sdh_pkg::ST_BATTERY, NOM_VREF,
                                      sdh_pkg::RAW_W'(2028), sdh_pkg::RAW_W'(2028),
                                      sdh_pkg::RAW_W'(2028), sdh_pkg::RAW_W'(2028)));
    pending_items.push_back(make_item(OP_POLL, sdh_pkg::ST_BATTERY, NOM_VREF,
                                      sdh_pkg::RAW_W'(2029), sdh_pkg::RAW_W'(2029),
                                      sdh_pkg::RAW_W'(2029), sdh_pkg::RAW_W'(2029)));
    // Smallest and largest reference readings, one sample out of step
    pending_items.push_back(make_item(OP_POLL, sdh_pkg::ST_BATTERY, sdh_pkg::RAW_W'(1),
                                      MAX_RAW, MAX_RAW, MAX_RAW, MAX_RAW));
    pending_items.push_back(make_item(OP_POLL, sdh_pkg::ST_BATTERY, MAX_RAW,
                                      '0, '0, '0, '0));
    pending_items.push_back(make_item(OP_POLL, sdh_pkg::ST_BATTERY, NOM_VREF,
                                      HI_RAW, HI_RAW, LO_RAW, HI_RAW));
    pending_items.push_back(make_item(OP_ALTER, sdh_pkg::ST_RESET, NOM_VREF,
                                      '0, '0, '0, '0));
  endtask

  // Wait until every item has gone in and every result has come out
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || status_due.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [sdh_pkg::DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= sdh_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      sdh_pkg::REG_UP_TH:    up_th_mv = val[sdh_pkg::TH_W-1:0];
      sdh_pkg::REG_DOWN_TH:  down_th_mv = val[sdh_pkg::TH_W-1:0];
      sdh_pkg::REG_VREF_CAL: cal_reading = val[sdh_pkg::CAL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic read_reg(logic [1:0] idx, logic [sdh_pkg::DATA_W-1:0] want);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= sdh_pkg::ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want)
      flag_mismatch($sformatf("register %0d read 0x%0h, want 0x%0h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Present queued items; predict each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) status_due.push_back(next_pred_status(cur_item));
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_item = pending_items.pop_front();
        in_op <= cur_item.op;
        in_requested_status <= cur_item.req;
        in_vrefint_raw <= cur_item.vref;
        in_sample_a <= cur_item.smp[0];
        in_sample_b <= cur_item.smp[1];
        in_sample_c <= cur_item.smp[2];
        in_confirm_sample <= cur_item.smp[3];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Take results and check them against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result, status %0d", out_status));
        end else if (out_status !== status_due[0]) begin
          flag_mismatch($sformatf("status %0d, want %0d", out_status, status_due[0]));
          void'(status_due.pop_front());
        end else begin
          void'(status_due.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    logic [sdh_pkg::TH_W-1:0]  new_up;
    logic [sdh_pkg::TH_W-1:0]  new_down;
    logic [sdh_pkg::CAL_W-1:0] new_cal;
    up_th_mv = sdh_pkg::UP_TH_RST;
    down_th_mv = sdh_pkg::DOWN_TH_RST;
    cal_reading = sdh_pkg::VREF_CAL_RST;
    mains_seen = 1'b0;
    pred_status = sdh_pkg::ST_BATTERY;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      // Idling pattern for this phase: none, sender, receiver, both
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      // Register settings: extremes first, then ordinary and random ones
      new_up = sdh_pkg::UP_TH_RST;
      new_down = sdh_pkg::DOWN_TH_RST;
      new_cal = sdh_pkg::VREF_CAL_RST;
      case (p)
        1: begin new_up = '0; new_down = '1; new_cal = '1; end
        2: begin new_up = '1; new_down = '0; new_cal = '0; end
        3: begin
          new_up = sdh_pkg::TH_W'(5200);
          new_down = sdh_pkg::TH_W'(4300);
          new_cal = sdh_pkg::CAL_W'(1500);
        end
        4: begin
          new_up = sdh_pkg::TH_W'($urandom_range(9000, 3000));
          new_down = new_up - sdh_pkg::TH_W'($urandom_range(1500));
          new_cal = sdh_pkg::CAL_W'($urandom_range(2200, 900));
        end
        default: ;
      endcase
      if (p > 0) begin
        write_reg(sdh_pkg::REG_UP_TH, sdh_pkg::DATA_W'(new_up));
        write_reg(sdh_pkg::REG_DOWN_TH, sdh_pkg::DATA_W'(new_down));
        write_reg(sdh_pkg::REG_VREF_CAL, sdh_pkg::DATA_W'(new_cal));
        read_reg(sdh_pkg::REG_UP_TH, sdh_pkg::DATA_W'(up_th_mv));
        read_reg(sdh_pkg::REG_DOWN_TH, sdh_pkg::DATA_W'(down_th_mv));
        read_reg(sdh_pkg::REG_VREF_CAL, sdh_pkg::DATA_W'(cal_reading));
      end else begin
        load_directed_items();
      end
      repeat (RANDOM_PER_PHASE) pending_items.push_back(random_item());
    end
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
